// File: design/clr_pkg.sv
`default_nettype none

package clr_pkg;

    // dimension registers and line coordinates
    localparam int DIM_W   = 13;
    // Q11.4 endpoint coordinates
    localparam int COORD_W = 16;
    localparam int COMP_W  = 8;
    localparam int PIX_W   = 12;
    localparam int ADDR_W  = 24;
    localparam int COLOR_W = 24;
    localparam int TWICE_W = 15;
    localparam int DEC_W   = 17;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } frame_cfg_t;

    typedef struct packed {
        cmd_t                command;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  end_x;
        logic [COORD_W-1:0]  end_y;
        logic [COMP_W-1:0]   red;
        logic [COMP_W-1:0]   green;
        logic [COMP_W-1:0]   blue;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } pixel_t;

endpackage

`default_nettype wire

// File: design/clipped_line_rasterizer.sv
`default_nettype none

// clipped line rasterizer: draws first-octant lines one pixel per beat. A load
// beat (command 0) takes two Q11.4 endpoints, adds one half to each and
// truncates toward zero, clamps the start at 0 and the end at the frame size,
// and latches the color; it yields no result. Each step beat (command 1) then
// walks one column with the Bresenham decision term and yields the pixel's
// x, y, word address y*frame_width+x, packed color and a last flag, or nothing
// when the pixel is off the frame or no line is active. Steep or reversed
// lines are not mirrored.
// Rate: one beat per clock, sustained while the sink keeps m_ready high; a
// beat that is taken is held in the input register, and its pixel moves into
// the result register when the step stage advances, which waits while a
// pending result is stalled. The rate is set by the single step stage, where
// the address multiply and the decision update are both combinational. The
// user writes frame registers through the cfg port only while no beat is in
// flight; the block itself does not enforce this. Values above MAX_DIM saturate.

module clipped_line_rasterizer #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_index,
    input  wire logic [clr_pkg::DIM_W-1:0]     cfg_wr_data,

    // command beats
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [clr_pkg::COORD_W-1:0]   s_start_x,
    input  wire logic [clr_pkg::COORD_W-1:0]   s_start_y,
    input  wire logic [clr_pkg::COORD_W-1:0]   s_end_x,
    input  wire logic [clr_pkg::COORD_W-1:0]   s_end_y,
    input  wire logic [clr_pkg::COMP_W-1:0]    s_red,
    input  wire logic [clr_pkg::COMP_W-1:0]    s_green,
    input  wire logic [clr_pkg::COMP_W-1:0]    s_blue,

    // pixel beats
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [clr_pkg::PIX_W-1:0]          m_pixel_x,
    output logic [clr_pkg::PIX_W-1:0]          m_pixel_y,
    output logic [clr_pkg::ADDR_W-1:0]         m_pixel_address,
    output logic [clr_pkg::COLOR_W-1:0]        m_pixel_color,
    output logic                               m_last
);

    clr_pkg::frame_cfg_t cfg;

    // input register
    logic                in_valid_reg, in_valid_next;
    clr_pkg::item_t      in_item_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    clr_pkg::pixel_t     out_pix_reg;

    // step stage handshake
    logic                advance;
    logic                emit;
    clr_pkg::pixel_t     pix;

    clr_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // the held beat moves through the step stage when the result register
    // is free or is being emptied in this cycle
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // the input register refills whenever it is empty or draining
    assign s_ready = !in_valid_reg || advance;

    clr_line_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .emit    (emit),
        .pix     (pix)
    );

    always_comb begin
        // input register occupancy
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        // result register occupancy: loads and off-frame steps leave it empty
        if (advance) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command <= clr_pkg::cmd_t'(s_command);
            in_item_reg.start_x <= s_start_x;
            in_item_reg.start_y <= s_start_y;
            in_item_reg.end_x   <= s_end_x;
            in_item_reg.end_y   <= s_end_y;
            in_item_reg.red     <= s_red;
            in_item_reg.green   <= s_green;
            in_item_reg.blue    <= s_blue;
        end
        if (advance && emit) begin
            out_pix_reg <= pix;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_x       = out_pix_reg.pixel_x;
    assign m_pixel_y       = out_pix_reg.pixel_y;
    assign m_pixel_address = out_pix_reg.pixel_address;
    assign m_pixel_color   = out_pix_reg.pixel_color;
    assign m_last          = out_pix_reg.last;

`ifndef SYNTHESIS
    // back pressure only when both registers are full and the sink stalls
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room downstream");

    // a blocked beat is kept in the input register
    a_blocked_beat_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("blocked beat dropped from input register");

    // a pending result is never overwritten by the step stage
    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("step stage advanced over a pending result");
`endif

endmodule

`default_nettype wire

// File: design/clr_cfg_regs.sv
`default_nettype none

module clr_cfg_regs #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_wr_index,
    input  wire logic [clr_pkg::DIM_W-1:0] cfg_wr_data,
    output clr_pkg::frame_cfg_t            cfg
);

    clr_pkg::frame_cfg_t  cfg_reg;
    logic [clr_pkg::DIM_W-1:0] value_sat;

    // values above the largest supported dimension saturate
    always_comb begin
        if (int'(cfg_wr_data) > MAX_DIM) begin
            value_sat = clr_pkg::DIM_W'(MAX_DIM);
        end else begin
            value_sat = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= clr_pkg::FRAME_WIDTH_RESET;
            cfg_reg.frame_height <= clr_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (clr_pkg::reg_index_t'(cfg_wr_index))
                clr_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= value_sat;
                clr_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= value_sat;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/clr_line_core.sv
`default_nettype none

module clr_line_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fire,
    input  clr_pkg::item_t     item,
    input  clr_pkg::frame_cfg_t cfg,
    output logic               emit,
    output clr_pkg::pixel_t    pix
);

    localparam int DW = clr_pkg::DIM_W;

    logic                          active_reg, active_next;
    logic [DW-1:0]                 cur_x_reg, cur_x_next;
    logic [DW-1:0]                 cur_y_reg, cur_y_next;
    logic [DW-1:0]                 stop_x_reg, stop_x_next;
    logic signed [clr_pkg::TWICE_W-1:0] twice_dx_reg, twice_dx_next;
    logic signed [clr_pkg::TWICE_W-1:0] twice_dy_reg, twice_dy_next;
    logic signed [clr_pkg::DEC_W-1:0]   decision_reg, decision_next;
    logic [clr_pkg::COLOR_W-1:0]   line_color_reg, line_color_next;

    // load path
    logic signed [DW-1:0]          x0_r, y0_r, x1_r, y1_r;
    logic [DW-1:0]                 x0, y0;
    logic signed [DW:0]            x1, y1;
    logic signed [clr_pkg::TWICE_W-1:0] dx, dy;

    // step path
    logic                          is_step;
    logic                          final_col;
    logic                          in_frame;
    logic signed [clr_pkg::DEC_W:0] dec_sum;
    logic [2*DW-1:0]               product;
    logic [2*DW:0]                 addr_full;

    // add one half in Q11.4, then truncate toward zero
    function automatic logic signed [DW-1:0] round_q4(
        input logic [clr_pkg::COORD_W-1:0] raw
    );
        logic signed [clr_pkg::COORD_W:0] q;
        logic [clr_pkg::COORD_W:0]        mag;
        q   = $signed({raw[clr_pkg::COORD_W-1], raw}) + 17'sd8;
        mag = '0;
        if (!q[clr_pkg::COORD_W]) begin
            round_q4 = DW'(q >>> 4);
        end else begin
            mag      = (clr_pkg::COORD_W+1)'(-q);
            round_q4 = -DW'(mag >> 4);
        end
    endfunction

    always_comb begin
        x0_r = round_q4(item.start_x);
        y0_r = round_q4(item.start_y);
        x1_r = round_q4(item.end_x);
        y1_r = round_q4(item.end_y);

        x0 = x0_r[DW-1] ? '0 : x0_r;
        y0 = y0_r[DW-1] ? '0 : y0_r;

        x1 = {x1_r[DW-1], x1_r};
        if (x1 > $signed({1'b0, cfg.frame_width})) begin
            x1 = $signed({1'b0, cfg.frame_width});
        end
        y1 = {y1_r[DW-1], y1_r};
        if (y1 > $signed({1'b0, cfg.frame_height})) begin
            y1 = $signed({1'b0, cfg.frame_height});
        end

        dx = $signed({x1[DW], x1}) - $signed({2'b00, x0});
        dy = $signed({y1[DW], y1}) - $signed({2'b00, y0});
    end

    always_comb begin
        is_step   = (item.command == clr_pkg::CMD_STEP);
        final_col = ({1'b0, cur_x_reg} + (DW+1)'(1)) >= {1'b0, stop_x_reg};
        in_frame  = (cur_x_reg < cfg.frame_width) && (cur_y_reg < cfg.frame_height);

        if (!decision_reg[clr_pkg::DEC_W-1]) begin
            dec_sum = $signed({decision_reg[clr_pkg::DEC_W-1], decision_reg})
                    + (clr_pkg::DEC_W+1)'(twice_dy_reg)
                    - (clr_pkg::DEC_W+1)'(twice_dx_reg);
        end else begin
            dec_sum = $signed({decision_reg[clr_pkg::DEC_W-1], decision_reg})
                    + (clr_pkg::DEC_W+1)'(twice_dy_reg);
        end

        product   = cur_y_reg * cfg.frame_width;
        addr_full = {1'b0, product} + (2*DW+1)'(cur_x_reg);

        emit              = fire && is_step && active_reg && in_frame;
        pix.pixel_x       = cur_x_reg[clr_pkg::PIX_W-1:0];
        pix.pixel_y       = cur_y_reg[clr_pkg::PIX_W-1:0];
        pix.pixel_address = addr_full[clr_pkg::ADDR_W-1:0];
        pix.pixel_color   = line_color_reg;
        pix.last          = final_col;
    end

    always_comb begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        stop_x_next     = stop_x_reg;
        twice_dx_next   = twice_dx_reg;
        twice_dy_next   = twice_dy_reg;
        decision_next   = decision_reg;
        line_color_next = line_color_reg;

        if (fire && !is_step) begin
            cur_x_next      = x0;
            cur_y_next      = y0;
            stop_x_next     = x1[DW-1:0];
            twice_dx_next   = {dx[clr_pkg::TWICE_W-2:0], 1'b0};
            twice_dy_next   = {dy[clr_pkg::TWICE_W-2:0], 1'b0};
            // start term stays well inside the decision range
            decision_next   = $signed({dy[clr_pkg::TWICE_W-1], dy, 1'b0})
                            - $signed({{2{dx[clr_pkg::TWICE_W-1]}}, dx});
            line_color_next = {item.red, item.green, item.blue};
            active_next     = $signed({1'b0, x0}) < x1;
        end else if (fire && active_reg) begin
            if (!decision_reg[clr_pkg::DEC_W-1]) begin
                cur_y_next = cur_y_reg + DW'(1);
            end
            if (dec_sum > $signed(18'sd65535)) begin
                decision_next = 17'sh0FFFF;
            end else if (dec_sum < -$signed(18'sd65536)) begin
                decision_next = 17'sh10000;
            end else begin
                decision_next = clr_pkg::DEC_W'(dec_sum);
            end
            cur_x_next = cur_x_reg + DW'(1);
            if (final_col) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            stop_x_reg     <= '0;
            twice_dx_reg   <= '0;
            twice_dy_reg   <= '0;
            decision_reg   <= '0;
            line_color_reg <= '0;
        end else begin
            active_reg     <= active_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            stop_x_reg     <= stop_x_next;
            twice_dx_reg   <= twice_dx_next;
            twice_dy_reg   <= twice_dy_next;
            decision_reg   <= decision_next;
            line_color_reg <= line_color_next;
        end
    end

`ifndef SYNTHESIS
    a_active_before_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (cur_x_reg < stop_x_reg))
        else $error("active line at or past its stop column");

    a_emit_needs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (active_reg && is_step && in_frame))
        else $error("pixel emitted without an active line");

    a_final_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_step && active_reg && final_col) |=> !active_reg)
        else $error("line still active after its final column");
`endif

endmodule

`default_nettype wire
